@@ hw/rtl/rhfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rhfd_pkg
// Shared types and constants of the readout half-frame decoder.
// ----------------------------------------------------------------------------
package rhfd_pkg;

    localparam int          FRAME_WORDS  = 40;
    localparam int          WIDX_W       = 6;
    localparam int          QUEUE_DEPTH  = 4;
    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [15:0] INVALID16    = 16'hFFFF;
    localparam logic [5:0]  CH_CAL       = 6'd36;
    localparam logic [5:0]  CH_CM_HI     = 6'd37;
    localparam logic [5:0]  CH_CM_LO     = 6'd38;
    localparam logic [5:0]  CH_SUMMARY   = 6'd39;
    localparam logic [3:0]  FRAME_NIBBLE = 4'h5;
    localparam logic [5:0]  LAST_WORD    = 6'(FRAME_WORDS - 1);
    localparam int          TDATA_W      = 96;

    // What the back end has to do with one queued word
    typedef enum logic [1:0] {
        KIND_CM,
        KIND_CHAN,
        KIND_SUM
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        half;
        logic [5:0]  chan;
        logic        crc_err;
        logic [31:0] data;      // frame word, or header word on the summary
    } t_job;

    // CRC-32 remainder of a single set bit j after 32 shift steps
    function automatic logic [31:0] crc_col(input int j);
        logic [31:0] v;
        v = 32'd1 << j;
        for (int b = 0; b < 32; b++) begin
            if (v[31]) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/rhfd_front.sv @@
// ----------------------------------------------------------------------------
// rhfd_front
// Word tracking, CRC update and classification of incoming frame words.
// ----------------------------------------------------------------------------
module rhfd_front import rhfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    input  logic        i_full,
    input  logic [1:0]  i_num_halves,
    output logic        o_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic [WIDX_W-1:0] r_idx;
    logic              r_half;
    logic [31:0]       r_header;
    logic [31:0]       r_crc;

    logic        w_acc;
    logic [31:0] w_crc_in;
    logic [31:0] w_terms [32];
    logic [31:0] n_crc;
    logic [5:0]  w_chan;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;

    // CRC restarts at the header word
    assign w_crc_in = ((r_idx == '0) ? 32'd0 : r_crc) ^ i_word;

    // Parallel CRC: xor of the column of every set bit
    for (genvar j = 0; j < 32; j++) begin : g_col
        localparam logic [31:0] COL = crc_col(j);
        assign w_terms[j] = w_crc_in[j] ? COL : 32'd0;
    end

    always_comb begin
        n_crc = 32'd0;
        for (int j = 0; j < 32; j++) begin
            n_crc = n_crc ^ w_terms[j];
        end
    end

    // Calibration word sits in the middle of the channel words
    always_comb begin
        if (r_idx <= 6'd19) begin
            w_chan = r_idx - 6'd2;
        end else if (r_idx == 6'd20) begin
            w_chan = CH_CAL;
        end else begin
            w_chan = r_idx - 6'd3;
        end
    end

    always_comb begin
        o_job.half    = r_half;
        o_job.chan    = w_chan;
        o_job.crc_err = (r_crc != i_word);
        o_job.data    = i_word;
        o_job.kind    = KIND_CHAN;
        if (r_idx == 6'd1) begin
            o_job.kind = KIND_CM;
        end else if (r_idx == LAST_WORD) begin
            o_job.kind = KIND_SUM;
            o_job.chan = CH_SUMMARY;
            o_job.data = r_header;
        end
    end

    assign o_push = w_acc && (r_idx != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_half   <= 1'b0;
            r_header <= '0;
            r_crc    <= '0;
        end else if (w_acc) begin
            if (r_idx == '0) begin
                r_header <= i_word;
            end
            if (r_idx == LAST_WORD) begin
                r_idx  <= '0;
                r_half <= !r_half && i_num_halves[1];
            end else begin
                r_idx <= r_idx + 1'b1;
                r_crc <= n_crc;
            end
        end
    end

endmodule

@@ hw/rtl/rhfd_queue.sv @@
// ----------------------------------------------------------------------------
// rhfd_queue
// Small FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module rhfd_queue import rhfd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/rhfd_back.sv @@
// ----------------------------------------------------------------------------
// rhfd_back
// Row builder: turns queued words into output rows in a registered stage.
// ----------------------------------------------------------------------------
module rhfd_back import rhfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_job               i_job,
    input  logic               i_ready,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_last,
    output logic               o_half,
    output logic [TDATA_W-1:0] o_data
);

    typedef struct packed {
        logic [4:0]  code;
        logic [2:0]  orbit;
        logic [5:0]  evt;
        logic [11:0] bx;
        logic [9:0]  toa;
        logic [15:0] tot;
        logic [15:0] adcm;
        logic [15:0] adc;
        logic [1:0]  flag;
        logic [5:0]  chan;
    } t_row;

    logic        r_valid;
    logic        r_last;
    logic        r_half;
    t_row        r_row;
    logic        r_pend;
    logic        r_pend_half;
    logic [9:0]  r_pend_adc;

    logic        w_load;
    t_row        w_row;
    t_row        w_cm_lo;
    logic        w_last;
    logic [9:0]  w_f10;
    logic [15:0] w_tot;
    logic [31:0] w_d;

    function automatic logic [15:0] expand_tot(input logic [9:0] t);
        if (t[9]) begin
            return {4'd0, t[8:0], 3'd0};
        end
        return {6'd0, t};
    endfunction

    assign w_load = !r_valid || i_ready;
    assign o_pop  = w_load && !r_pend && !i_empty;
    assign w_d    = i_job.data;
    assign w_f10  = w_d[19:10];
    assign w_tot  = expand_tot(w_f10);

    // second common-mode row
    always_comb begin
        w_cm_lo      = '0;
        w_cm_lo.chan = CH_CM_LO;
        w_cm_lo.adc  = {6'd0, r_pend_adc};
    end

    always_comb begin
        w_row      = '0;
        w_last     = 1'b1;
        w_row.chan = i_job.chan;
        case (i_job.kind)
            KIND_CM: begin
                w_row.chan = CH_CM_HI;
                w_row.adc  = {6'd0, w_f10};
                w_last     = 1'b0;
            end
            KIND_CHAN: begin
                w_row.flag = w_d[31:30];
                w_row.toa  = w_d[9:0];
                if (i_job.chan == CH_CAL) begin
                    w_row.adc  = {6'd0, w_d[29:20]};
                    w_row.adcm = INVALID16;
                    w_row.tot  = w_tot;
                end else begin
                    w_row.adcm = {6'd0, w_d[29:20]};
                    w_row.adc  = w_d[31] ? INVALID16 : {6'd0, w_f10};
                    w_row.tot  = w_d[31] ? w_tot : INVALID16;
                end
            end
            KIND_SUM: begin
                w_row.bx    = w_d[27:16];
                w_row.evt   = w_d[15:10];
                w_row.orbit = w_d[9:7];
                w_row.code  = {w_d[6:4], i_job.crc_err,
                               !(w_d[31:28] == FRAME_NIBBLE && w_d[3:0] == FRAME_NIBBLE)};
            end
            default: begin
                w_row = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid  <= 1'b1;
                r_pend   <= 1'b0;
                r_last   <= 1'b1;
                r_half   <= r_pend_half;
                r_row    <= w_cm_lo;
            end else if (!i_empty) begin
                r_valid     <= 1'b1;
                r_pend      <= (i_job.kind == KIND_CM);
                r_pend_half <= i_job.half;
                r_pend_adc  <= w_d[9:0];
                r_last      <= w_last;
                r_half      <= i_job.half;
                r_row       <= w_row;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_half  = r_half;
    assign o_data  = {4'd0, r_row};

endmodule

@@ hw/rtl/readout_half_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// readout_half_frame_decoder
// Unpacks 40-word readout half frames into rows and checks their CRC-32.
// ----------------------------------------------------------------------------
// Input stream s_axis: one 32-bit frame word per handshake. Word 0 is the
// header, word 1 the common-mode word, words 2..38 channel words, word 39 the
// CRC. Output stream m_axis: one row per output word; tlast marks the final
// row that a frame word produces, tuser is the half index. The header gives
// no row, the common-mode word gives two, all other words one.
// With the output free, an accepted word is registered in the queue, then
// its row in the output register; the second common-mode row is loaded once
// the first is taken. Throughput: one word per cycle while the queue is not
// full; the common-mode word occupies the row builder for both its rows, the
// header leaves it free, and the four-entry queue between front end and row
// builder absorbs that over a whole frame (40 rows).
// APB: register 0 (address 0) holds num_halves, reset value 2; values 2 and 3
// alternate the halves, 0 and 1 keep half 0. A change is taken at the next
// end of a half frame. Write only while the stream is idle.
// Reset clears the word index, half, CRC and queue; no row is pending.
// When m_axis stalls, rows wait in the output register and the queue, and
// s_axis_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module readout_half_frame_decoder import rhfd_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] frame_word
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [5:0] chan_id, [7:6] tot_flag, [23:8] adc_value, [39:24] adcm_value,
    // [55:40] tot_value, [65:56] toa_value, [77:66] bx_count,
    // [83:78] event_count, [86:84] orbit_count, [91:87] corruption_code
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,
    output logic               m_axis_tuser,   // [0] half_id
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0] r_num_halves;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, r_num_halves} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_halves <= 2'd2;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_num_halves <= pwdata[1:0];
        end
    end

    rhfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_word       (s_axis_tdata),
        .i_full       (w_full),
        .i_num_halves (r_num_halves),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    rhfd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    rhfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .i_ready (m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_half  (m_axis_tuser),
        .o_data  (m_axis_tdata)
    );

endmodule
